### src/rwmc_pkg.sv
// Shared types, constants and helpers for the random-walk maze carver.
// Used by every module of the block; depends on nothing else.
package rwmc_pkg;

  localparam int MAX_WIDTH = 32;
  localparam int MAX_HEIGHT = 32;
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int ADDR_W = ROW_W + COL_W;
  localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
  localparam int SIZE_W = 6;
  localparam int COUNT_W = 11;
  localparam int SIZE_RESET = 8;
  localparam int EPOCH_W = 8;
  localparam int EPOCH_LAST = (1 << EPOCH_W) - 1;
  localparam int CFG_IDX_W = 2;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int LEVEL_W = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [0:0] {
    REQ_RESTART = 1'b0,
    REQ_STEP    = 1'b1
  } req_type_t;

  typedef enum logic [1:0] {
    DIR_ROW_DEC = 2'd0,
    DIR_ROW_INC = 2'd1,
    DIR_COL_DEC = 2'd2,
    DIR_COL_INC = 2'd3
  } dir_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    req_type_t req_type;
    dir_t      direction;
  } req_t;

  typedef struct packed {
    logic [4:0] cursor_col;
    logic [4:0] cursor_row;
    logic       carved;
    logic       wall_is_column_edge;
    logic [5:0] wall_row;
    logic [5:0] wall_col;
    logic       done_res;
  } rsp_t;

  typedef struct packed {
    logic [SIZE_W-1:0]  w;
    logic [SIZE_W-1:0]  h;
    logic [COUNT_W-1:0] total;
  } grid_t;

  typedef struct packed {
    logic              restart;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
  } mem_req_t;

  typedef struct packed {
    logic hit;
    logic busy;
  } mem_rsp_t;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] maxv);
    logic [SIZE_W-1:0] r;
    begin
      r = v;
      if (v < SIZE_W'(2)) begin
        r = SIZE_W'(2);
      end else if (v > maxv) begin
        r = maxv;
      end
      return r;
    end
  endfunction

endpackage

### src/rwmc_cfg.sv
// Size registers of the maze carver: clamped width, height and cell total.
// Depends on rwmc_pkg; a write to a size register also restarts the maze.
module rwmc_cfg import rwmc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0]    cfg_data,
  output grid_t                grid,
  output logic                 restart
);

  logic [SIZE_W-1:0]   w_next;
  logic [SIZE_W-1:0]   h_next;
  logic [2*SIZE_W-1:0] prod;

  assign cfg_ready = 1'b1;

  always_comb begin
    w_next = grid.w;
    h_next = grid.h;
    restart = 1'b0;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_WIDTH: begin
          w_next = clamp_size(cfg_data, SIZE_W'(MAX_WIDTH));
          restart = 1'b1;
        end
        CFG_HEIGHT: begin
          h_next = clamp_size(cfg_data, SIZE_W'(MAX_HEIGHT));
          restart = 1'b1;
        end
        default: begin
        end
      endcase
    end
    prod = w_next * h_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grid.w <= SIZE_W'(SIZE_RESET);
      grid.h <= SIZE_W'(SIZE_RESET);
      grid.total <= COUNT_W'(SIZE_RESET * SIZE_RESET);
    end else begin
      grid.w <= w_next;
      grid.h <= h_next;
      grid.total <= prod[COUNT_W-1:0];
    end
  end

endmodule

### src/rwmc_visit_mem.sv
// Visited map of the maze carver, kept as epoch tags in one synchronous memory.
// Depends on rwmc_pkg. A cell is visited when its tag equals the current epoch.
module rwmc_visit_mem import rwmc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  mem_req_t req,
  output mem_rsp_t rsp
);

  logic [EPOCH_W-1:0] mem [CELLS];
  logic [EPOCH_W-1:0] rdata;
  logic [EPOCH_W-1:0] epoch;
  logic               sweeping;
  logic [ADDR_W-1:0]  sweep_addr;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [EPOCH_W-1:0] mem_wdata;

  always_comb begin
    mem_we = req.wr_en || sweeping;
    mem_waddr = req.wr_en ? req.wr_addr : sweep_addr;
    mem_wdata = req.wr_en ? epoch : '0;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (req.rd_en) begin
      rdata <= mem[req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      epoch <= EPOCH_W'(1);
      sweeping <= 1'b1;
      sweep_addr <= '0;
    end else if (req.restart && epoch == EPOCH_W'(EPOCH_LAST)) begin
      epoch <= EPOCH_W'(1);
      sweeping <= 1'b1;
      sweep_addr <= '0;
    end else begin
      if (req.restart) begin
        epoch <= epoch + 1'b1;
      end
      if (sweeping && !req.wr_en) begin
        sweep_addr <= sweep_addr + 1'b1;
        if (sweep_addr == ADDR_W'(CELLS - 1)) begin
          sweeping <= 1'b0;
        end
      end
    end
  end

  assign rsp.hit = (rdata == epoch);
  assign rsp.busy = sweeping;

endmodule

### src/rwmc_walk.sv
// Walk engine of the maze carver: cursor, drawn count and the read-compare-write
// stage around the visited map. Depends on rwmc_pkg.
module rwmc_walk import rwmc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  req_t               in_data,
  input  logic               cfg_restart,
  input  grid_t              grid,
  input  logic [LEVEL_W-1:0] level,
  output logic               push,
  output rsp_t               push_data,
  output mem_req_t           mreq,
  input  mem_rsp_t           mrsp
);

  logic [ROW_W-1:0]   cur_row;
  logic [COL_W-1:0]   cur_col;
  logic [COUNT_W-1:0] count;

  logic               s1_valid;
  logic               s1_step;
  logic               s1_moved;
  logic               s1_fwd;
  logic [ROW_W-1:0]   s1_row;
  logic [COL_W-1:0]   s1_col;
  logic               s1_col_edge;
  logic [SIZE_W-1:0]  s1_wrow;
  logic [SIZE_W-1:0]  s1_wcol;
  logic               s1_carve;

  logic               accept;
  logic               is_step;
  logic               done_eff;
  logic               move;
  logic               room;
  logic               restart_any;
  logic               fwd;
  logic [SIZE_W-1:0]  row_up;
  logic [SIZE_W-1:0]  col_up;
  logic [ROW_W-1:0]   nr;
  logic [COL_W-1:0]   nc;
  logic               col_edge;
  logic [SIZE_W-1:0]  wrow;
  logic [SIZE_W-1:0]  wcol;
  logic [COUNT_W-1:0] count_after;

  assign s1_carve = s1_valid && s1_step && s1_moved &&
                    !(s1_fwd || mrsp.hit || (s1_row == '0 && s1_col == '0));

  always_comb begin
    room = s1_valid ? (level < LEVEL_W'(FIFO_DEPTH - 1)) : (level < LEVEL_W'(FIFO_DEPTH));
    in_ready = !mrsp.busy && room;
    accept = in_valid && in_ready;
    is_step = (in_data.req_type == REQ_STEP);
    done_eff = (count >= grid.total) ||
               ((count == grid.total - 1'b1) && s1_carve);
    move = is_step && !done_eff;
    restart_any = cfg_restart || (accept && !is_step);

    row_up = SIZE_W'(cur_row) + 1'b1;
    col_up = SIZE_W'(cur_col) + 1'b1;
    nr = cur_row;
    nc = cur_col;
    col_edge = 1'b0;
    case (in_data.direction)
      DIR_ROW_DEC: nr = (cur_row == '0) ? ROW_W'(1) : cur_row - 1'b1;
      DIR_ROW_INC: nr = (row_up >= grid.h) ? cur_row - 1'b1 : cur_row + 1'b1;
      DIR_COL_DEC: nc = (cur_col == '0) ? COL_W'(1) : cur_col - 1'b1;
      DIR_COL_INC: nc = (col_up >= grid.w) ? cur_col - 1'b1 : cur_col + 1'b1;
      default: begin
      end
    endcase

    if (in_data.direction == DIR_ROW_DEC || in_data.direction == DIR_ROW_INC) begin
      col_edge = 1'b0;
      wrow = SIZE_W'((nr > cur_row) ? nr : cur_row);
      wcol = SIZE_W'(cur_col);
    end else begin
      col_edge = 1'b1;
      wrow = SIZE_W'(cur_row);
      wcol = SIZE_W'((nc > cur_col) ? nc : cur_col);
    end

    fwd = s1_carve && (s1_row == nr) && (s1_col == nc);

    mreq.restart = restart_any;
    mreq.rd_en = accept && move;
    mreq.rd_addr = {nr, nc};
    mreq.wr_en = s1_carve;
    mreq.wr_addr = {s1_row, s1_col};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      cur_row <= '0;
      cur_col <= '0;
      count <= COUNT_W'(1);
    end else begin
      s1_valid <= accept;
      if (restart_any) begin
        cur_row <= '0;
        cur_col <= '0;
      end else if (accept && move) begin
        cur_row <= nr;
        cur_col <= nc;
      end
      if (restart_any) begin
        count <= COUNT_W'(1);
      end else if (s1_carve) begin
        count <= count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_step <= is_step;
      s1_moved <= move;
      s1_fwd <= fwd;
      s1_row <= is_step ? (move ? nr : cur_row) : '0;
      s1_col <= is_step ? (move ? nc : cur_col) : '0;
      s1_col_edge <= col_edge;
      s1_wrow <= wrow;
      s1_wcol <= wcol;
    end
  end

  always_comb begin
    count_after = count + COUNT_W'(s1_carve);
    push = s1_valid;
    push_data.cursor_col = s1_col;
    push_data.cursor_row = s1_row;
    push_data.carved = s1_carve;
    push_data.wall_is_column_edge = s1_carve && s1_col_edge;
    push_data.wall_row = s1_carve ? s1_wrow : '0;
    push_data.wall_col = s1_carve ? s1_wcol : '0;
    push_data.done_res = (count_after >= grid.total);
  end

  a_cursor_in_grid: assert property (@(posedge clk) disable iff (rst)
    (SIZE_W'(cur_row) < grid.h) && (SIZE_W'(cur_col) < grid.w))
    else $error("cursor outside the grid in use");

  a_carve_below_total: assert property (@(posedge clk) disable iff (rst)
    s1_carve |-> (count < grid.total))
    else $error("cell carved after the maze was complete");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    s1_valid |=> (count <= grid.total))
    else $error("drawn count exceeds the number of cells");

endmodule

### src/rwmc_out_fifo.sv
// Four-entry result queue of the maze carver; decouples the walk stage from
// the output handshake. Depends on rwmc_pkg.
module rwmc_out_fifo import rwmc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  rsp_t               push_data,
  output logic               out_valid,
  input  logic               out_ready,
  output rsp_t               out_data,
  output logic [LEVEL_W-1:0] level
);

  rsp_t                  entries [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic                  pop;

  assign out_valid = (level != '0);
  assign pop = out_valid && out_ready;
  assign out_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      level <= level + LEVEL_W'(push) - LEVEL_W'(pop);
    end
  end

endmodule

### src/random_walk_maze_carver.sv
// Random-walk maze carver. Each input beat passes the registered walk stage into
// the output queue, and one item is taken every cycle while the queue has room and
// no clearing pass runs: the visited map is read in the accept cycle and written
// back in the next, with the previous write forwarded. After reset, and after every
// 255th restart, a clearing pass runs through the visited memory while in_ready
// stays low; config writes are taken. Reset restores an 8 by 8 grid, cursor (0,0).
module random_walk_maze_carver import rwmc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  req_t                 in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output rsp_t                 out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0]    cfg_data
);

  grid_t              grid;
  logic               cfg_restart;
  mem_req_t           mreq;
  mem_rsp_t           mrsp;
  logic               push;
  rsp_t               push_data;
  logic [LEVEL_W-1:0] level;

  rwmc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .grid      (grid),
    .restart   (cfg_restart)
  );

  rwmc_visit_mem u_visit (
    .clk (clk),
    .rst (rst),
    .req (mreq),
    .rsp (mrsp)
  );

  rwmc_walk u_walk (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .cfg_restart (cfg_restart),
    .grid        (grid),
    .level       (level),
    .push        (push),
    .push_data   (push_data),
    .mreq        (mreq),
    .mrsp        (mrsp)
  );

  rwmc_out_fifo u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .level     (level)
  );

endmodule

### tb/tb.sv
// Self-checking testbench for random_walk_maze_carver: directed rows, then random walks.
// Carries its own model of the walk, the visited map and the size registers.
// Depends on rwmc_pkg and the carver RTL only.
`timescale 1ns / 100ps

module tb;
  import rwmc_pkg::*;

  localparam int QUIET_LIMIT = 5000;
  localparam int HOLD_CYCLES = 100;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  typedef enum logic {
    STIM_BEAT,
    STIM_REG
  } stim_kind_t;

  typedef struct {
    stim_kind_t           kind;
    req_t                 req;
    logic [CFG_IDX_W-1:0] idx;
    logic [SIZE_W-1:0]    value;
    bit                   typed;
    rsp_t                 want;
  } stim_row_t;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  req_t                 in_data;
  logic                 out_valid;
  logic                 out_ready;
  rsp_t                 out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [SIZE_W-1:0]    cfg_data;

  bit                visited_cells [0:CELLS-1];
  logic [4:0]        walk_col;
  logic [4:0]        walk_row;
  logic [10:0]       drawn;
  logic [SIZE_W-1:0] width_reg;
  logic [SIZE_W-1:0] height_reg;

  rsp_t      pending_walk [$];
  stim_row_t directed [$];
  rsp_t      front_rsp;

  bit calm = 1'b0;
  bit hold_request = 1'b0;
  int hold_left = 0;
  int quiet = 0;
  int mismatches = 0;
  int items_sent = 0;
  int restarts_sent = 0;
  int reg_writes = 0;
  int carves_seen = 0;
  int done_seen = 0;

  random_walk_maze_carver dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int grid_dim(logic [SIZE_W-1:0] v, int maxv);
    if (v < 2) return 2;
    if (v > maxv) return maxv;
    return int'(v);
  endfunction

  function automatic void clear_walk();
    foreach (visited_cells[i]) visited_cells[i] = 1'b0;
    visited_cells[0] = 1'b1;
    walk_col = '0;
    walk_row = '0;
    drawn = 11'd1;
  endfunction

  function automatic rsp_t predict_walk(req_t r);
    rsp_t e;
    int w, h, total, pr, pc, nr, nc;
    w = grid_dim(width_reg, MAX_WIDTH);
    h = grid_dim(height_reg, MAX_HEIGHT);
    total = w * h;
    e = '0;
    if (r.req_type == REQ_RESTART) begin
      clear_walk();
    end else if (drawn < total) begin
      pr = walk_row;
      pc = walk_col;
      nr = pr;
      nc = pc;
      case (r.direction)
        DIR_ROW_DEC: nr = (pr == 0) ? pr + 1 : pr - 1;
        DIR_ROW_INC: nr = (pr + 1 >= h) ? pr - 1 : pr + 1;
        DIR_COL_DEC: nc = (pc == 0) ? pc + 1 : pc - 1;
        default:     nc = (pc + 1 >= w) ? pc - 1 : pc + 1;
      endcase
      walk_row = 5'(nr);
      walk_col = 5'(nc);
      if (!visited_cells[nr * MAX_WIDTH + nc]) begin
        visited_cells[nr * MAX_WIDTH + nc] = 1'b1;
        drawn = drawn + 11'd1;
        e.carved = 1'b1;
        if (r.direction == DIR_ROW_DEC || r.direction == DIR_ROW_INC) begin
          e.wall_row = 6'((nr > pr) ? nr : pr);
          e.wall_col = 6'(pc);
        end else begin
          e.wall_is_column_edge = 1'b1;
          e.wall_row = 6'(pr);
          e.wall_col = 6'((nc > pc) ? nc : pc);
        end
      end
    end
    e.cursor_col = walk_col;
    e.cursor_row = walk_row;
    e.done_res = (drawn >= total);
    return e;
  endfunction

  function automatic rsp_t walk_rsp(int col, int row, bit carve, bit col_edge, int wr, int wc,
                                    bit done);
    rsp_t e;
    e.cursor_col = 5'(col);
    e.cursor_row = 5'(row);
    e.carved = carve;
    e.wall_is_column_edge = col_edge;
    e.wall_row = 6'(wr);
    e.wall_col = 6'(wc);
    e.done_res = done;
    return e;
  endfunction

  function automatic void add_beat(req_type_t t, dir_t d, bit typed = 1'b0, rsp_t want = '0);
    stim_row_t row;
    row.kind = STIM_BEAT;
    row.req.req_type = t;
    row.req.direction = d;
    row.idx = '0;
    row.value = '0;
    row.typed = typed;
    row.want = want;
    directed.push_back(row);
  endfunction

  function automatic void add_reg(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] value);
    stim_row_t row;
    row.kind = STIM_REG;
    row.req = '0;
    row.idx = idx;
    row.value = value;
    row.typed = 1'b0;
    row.want = '0;
    directed.push_back(row);
  endfunction

  function automatic req_t random_req(int restart_pct);
    req_t r;
    r.req_type = ($urandom_range(0, 99) < restart_pct) ? REQ_RESTART : REQ_STEP;
    r.direction = dir_t'($urandom_range(0, 3));
    return r;
  endfunction

  function automatic logic [SIZE_W-1:0] pick_size();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return SIZE_W'($urandom_range(2, 5));
    if (roll < 85) return SIZE_W'($urandom_range(6, 32));
    return SIZE_W'($urandom_range(0, 63));
  endfunction

  function automatic void check_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endfunction

  task automatic send_item(req_t d, bit typed, rsp_t typed_rsp);
    rsp_t predicted;
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < 31) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= d;
    do @(posedge clk); while (!in_ready);
    predicted = predict_walk(d);
    pending_walk.push_back(typed ? typed_rsp : predicted);
    items_sent++;
    if (d.req_type == REQ_RESTART) restarts_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_walk.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_WIDTH) begin
      width_reg = value;
      clear_walk();
    end else if (idx == CFG_HEIGHT) begin
      height_reg = value;
      clear_walk();
    end
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic walk_phase(int n_items, int restart_pct, bit hold = 1'b0);
    drain();
    if ($urandom_range(0, 1)) begin
      write_reg(CFG_WIDTH, pick_size());
      write_reg(CFG_HEIGHT, pick_size());
    end else begin
      write_reg(CFG_HEIGHT, pick_size());
      write_reg(CFG_WIDTH, pick_size());
    end
    if ($urandom_range(0, 3) == 0)
      write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, SIZE_W'($urandom_range(0, 63)));
    if (hold) hold_request = 1'b1;
    send_item(random_req(100), 1'b0, '0);
    repeat (n_items - 1) send_item(random_req(restart_pct), 1'b0, '0);
  endtask

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(0, 99) >= 31);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_walk.size() == 0) begin
        $error("result beat with no expectation pending");
        mismatches++;
      end else begin
        front_rsp = pending_walk.pop_front();
        check_field("cursor_col", front_rsp.cursor_col, out_data.cursor_col);
        check_field("cursor_row", front_rsp.cursor_row, out_data.cursor_row);
        check_field("carved", front_rsp.carved, out_data.carved);
        check_field("wall_is_column_edge", front_rsp.wall_is_column_edge,
                    out_data.wall_is_column_edge);
        check_field("wall_row", front_rsp.wall_row, out_data.wall_row);
        check_field("wall_col", front_rsp.wall_col, out_data.wall_col);
        check_field("done_res", front_rsp.done_res, out_data.done_res);
        if (out_data.carved) carves_seen++;
        if (out_data.done_res) done_seen++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet + 1 >= QUIET_LIMIT) begin
        $error("no beat moved for %0d cycles, %0d results outstanding", QUIET_LIMIT,
               pending_walk.size());
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    width_reg = SIZE_W'(SIZE_RESET);
    height_reg = SIZE_W'(SIZE_RESET);
    clear_walk();

    add_beat(REQ_RESTART, DIR_ROW_DEC, 1'b1, walk_rsp(0, 0, 0, 0, 0, 0, 0));
    add_beat(REQ_STEP, DIR_ROW_DEC, 1'b1, walk_rsp(0, 1, 1, 0, 1, 0, 0));
    add_beat(REQ_STEP, DIR_COL_DEC);
    add_beat(REQ_STEP, DIR_ROW_DEC);
    add_beat(REQ_STEP, DIR_COL_INC);
    add_beat(REQ_STEP, DIR_COL_DEC);
    add_reg(CFG_WIDTH, 6'd0);
    add_reg(CFG_HEIGHT, 6'd1);
    add_beat(REQ_STEP, DIR_ROW_INC);
    add_beat(REQ_STEP, DIR_ROW_INC);
    add_beat(REQ_STEP, DIR_COL_INC);
    add_beat(REQ_STEP, DIR_COL_INC);
    add_beat(REQ_STEP, DIR_COL_INC);
    add_beat(REQ_STEP, DIR_ROW_INC);
    add_beat(REQ_STEP, DIR_ROW_DEC, 1'b1, walk_rsp(1, 1, 0, 0, 0, 0, 1));
    add_reg(CFG_SPARE_A, 6'd63);
    add_reg(CFG_SPARE_B, 6'd0);
    add_beat(REQ_STEP, DIR_COL_DEC, 1'b1, walk_rsp(1, 1, 0, 0, 0, 0, 1));
    add_beat(REQ_RESTART, DIR_COL_INC, 1'b1, walk_rsp(0, 0, 0, 0, 0, 0, 0));
    add_reg(CFG_WIDTH, 6'd63);
    add_reg(CFG_HEIGHT, 6'd32);
    add_beat(REQ_STEP, DIR_COL_DEC);
    add_beat(REQ_STEP, DIR_ROW_DEC);
    add_beat(REQ_STEP, DIR_COL_INC);
    add_beat(REQ_STEP, DIR_ROW_INC);
    add_reg(CFG_WIDTH, 6'd33);
    add_reg(CFG_HEIGHT, 6'd2);
    add_beat(REQ_STEP, DIR_ROW_INC);
    add_beat(REQ_STEP, DIR_ROW_INC);
    add_beat(REQ_RESTART, DIR_ROW_INC);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed[i]) begin
      if (directed[i].kind == STIM_REG) begin
        drain();
        write_reg(directed[i].idx, directed[i].value);
      end else begin
        send_item(directed[i].req, directed[i].typed, directed[i].want);
      end
    end

    walk_phase(60, 5);
    calm = 1'b1;
    walk_phase(60, 5);
    calm = 1'b0;
    walk_phase(60, 5, 1'b1);
    walk_phase(60, 10);

    // Dense restarts push the block through a full wrap of its restart epochs.
    repeat (260) begin
      send_item(random_req(100), 1'b0, '0);
      repeat ($urandom_range(0, 1)) send_item(random_req(0), 1'b0, '0);
    end

    repeat (4) walk_phase(55, 5);

    drain();
    repeat (8) @(posedge clk);

    $display("Run covered %0d input beats (%0d restarts) and %0d register writes.",
             items_sent, restarts_sent, reg_writes);
    $display("Results showed %0d carved walls and %0d finished-maze beats.",
             carves_seen, done_seen);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
